// ===== hdl/coalescing_update_ring_queue_unit_macros.svh =====
// Assertion macros used by the checker of the coalescing update ring queue.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef COALESCING_UPDATE_RING_QUEUE_UNIT_MACROS_SVH
`define COALESCING_UPDATE_RING_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CURQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CURQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/curq_pkg.sv =====
// Package of the coalescing update ring queue: field widths, command codes and
// the control group that the top level broadcasts to the slot cells. No dependencies.
package curq_pkg;

	localparam int MATCH_W = 8;
	localparam int INDEX_W = 4;
	localparam int VALUE_W = 64;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// One phase strobe per cell operation; at most one is high in a cycle.
	typedef struct packed {
		logic compare;
		logic shift;
		logic append;
	} curq_ctl_t;

endpackage

// ===== hdl/curq_cell.sv =====
// One slot cell of the coalescing update ring queue: holds a key and value word,
// compares them with a pushed update, shifts from its neighbor and drives the read chain.
// Depends on curq_pkg.
module curq_cell #(
	parameter int DEPTH = 16,
	parameter int INDEX = 0,
	localparam int PW = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  curq_pkg::curq_ctl_t          ctl,
	input  logic [PW-1:0]                rp,
	input  logic [PW-1:0]                wp,
	input  logic [PW-1:0]                scan_pos,
	input  logic [PW-1:0]                shift_end,
	input  logic [curq_pkg::MATCH_W-1:0] key_match,
	input  logic [curq_pkg::INDEX_W-1:0] key_index,
	input  logic [curq_pkg::VALUE_W-1:0] key_value,
	input  logic [curq_pkg::MATCH_W-1:0] nxt_match,
	input  logic [curq_pkg::INDEX_W-1:0] nxt_index,
	input  logic [curq_pkg::VALUE_W-1:0] nxt_value,
	input  logic [curq_pkg::MATCH_W-1:0] bus_in_match,
	input  logic [curq_pkg::INDEX_W-1:0] bus_in_index,
	input  logic [curq_pkg::VALUE_W-1:0] bus_in_value,
	output logic [curq_pkg::MATCH_W-1:0] bus_match,
	output logic [curq_pkg::INDEX_W-1:0] bus_index,
	output logic [curq_pkg::VALUE_W-1:0] bus_value,
	output logic [curq_pkg::MATCH_W-1:0] slot_match,
	output logic [curq_pkg::INDEX_W-1:0] slot_index,
	output logic [curq_pkg::VALUE_W-1:0] slot_value,
	output logic                         hit_key,
	output logic                         hit_val
);

	localparam logic [PW-1:0] MY_SLOT = PW'(INDEX);

	logic [curq_pkg::MATCH_W-1:0] match_q;
	logic [curq_pkg::INDEX_W-1:0] index_q;
	logic [curq_pkg::VALUE_W-1:0] value_q;
	logic [curq_pkg::MATCH_W-1:0] bus_match_q;
	logic [curq_pkg::INDEX_W-1:0] bus_index_q;
	logic [curq_pkg::VALUE_W-1:0] bus_value_q;
	logic                         hit_key_q;
	logic                         hit_val_q;
	logic                         shift_go;
	logic                         load_go;

	// Distance from b forward to a around the ring.
	function automatic logic [PW:0] ring_dist(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] d;
		if (a >= b) begin
			d = {1'b0, a} - {1'b0, b};
		end else begin
			d = {1'b0, a} + (PW+1)'(DEPTH) - {1'b0, b};
		end
		return d;
	endfunction

	// Cells from the removed slot up to the one before the last entry move down.
	assign shift_go = ctl.shift &&
		(ring_dist(MY_SLOT, scan_pos) < ring_dist(shift_end, scan_pos));
	assign load_go  = ctl.append && (MY_SLOT == wp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= '0;
			index_q     <= '0;
			value_q     <= '0;
			hit_key_q   <= 1'b0;
			hit_val_q   <= 1'b0;
			bus_match_q <= '0;
			bus_index_q <= '0;
			bus_value_q <= '0;
		end else begin
			priority if (shift_go) begin
				match_q <= nxt_match;
				index_q <= nxt_index;
				value_q <= nxt_value;
			end else if (load_go) begin
				match_q <= key_match;
				index_q <= key_index;
				value_q <= key_value;
			end
			if (ctl.compare) begin
				hit_key_q <= (match_q == key_match) && (index_q == key_index);
				hit_val_q <= (value_q == key_value);
			end
			if (MY_SLOT == rp) begin
				bus_match_q <= match_q;
				bus_index_q <= index_q;
				bus_value_q <= value_q;
			end else begin
				bus_match_q <= bus_in_match;
				bus_index_q <= bus_in_index;
				bus_value_q <= bus_in_value;
			end
		end
	end

	assign slot_match = match_q;
	assign slot_index = index_q;
	assign slot_value = value_q;
	assign bus_match  = bus_match_q;
	assign bus_index  = bus_index_q;
	assign bus_value  = bus_value_q;
	assign hit_key    = hit_key_q;
	assign hit_val    = hit_val_q;

endmodule

// ===== hdl/coalescing_update_ring_queue_unit.sv =====
// Coalescing update ring queue: top level with the command sequencer and the row of slot cells.
// Depends on curq_pkg and curq_cell.
// Sequence: a push walks through compare, a backward scan of one slot per cycle, optional
//   shift and append; a pop of a non-empty queue waits while the read chain carries the oldest
//   entry to its end; every other command is answered straight from idle.
// Throughput: one command at a time; the next start is taken in the cycle its result shows.
// Reset: all slots zero, both pointers zero, queue empty; no clearing pass is needed.
module coalescing_update_ring_queue_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [1:0]                   command,
	input  logic [curq_pkg::MATCH_W-1:0] match_id,
	input  logic [curq_pkg::INDEX_W-1:0] entry_index,
	input  logic [curq_pkg::VALUE_W-1:0] update_value,
	output logic                         busy,
	output logic                         done,
	output logic                         notify,
	output logic                         overwrote,
	output logic                         pop_valid,
	output logic [curq_pkg::MATCH_W-1:0] out_match,
	output logic [curq_pkg::INDEX_W-1:0] out_index,
	output logic [curq_pkg::VALUE_W-1:0] out_value
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

	// The sequencer walks a push through compare, scan, shift and append, and
	// holds a pop in place while the read chain delivers the oldest entry.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_SCAN,
		ST_SHIFT,
		ST_APPEND,
		ST_POP
	} state_t;

	state_t                       state_q;
	logic [PW-1:0]                rp_q;
	logic [PW-1:0]                wp_q;
	logic                         empty_q;
	logic [PW-1:0]                pos_q;
	logic                         pending_q;
	logic [PW-1:0]                cnt_q;
	logic                         done_q;
	logic                         notify_q;
	logic                         overwrote_q;
	logic                         pop_valid_q;
	logic [curq_pkg::MATCH_W-1:0] out_match_q;
	logic [curq_pkg::INDEX_W-1:0] out_index_q;
	logic [curq_pkg::VALUE_W-1:0] out_value_q;

	// Operand of the push that is in flight; taken when a beat is accepted.
	logic [curq_pkg::MATCH_W-1:0] key_match_q;
	logic [curq_pkg::INDEX_W-1:0] key_index_q;
	logic [curq_pkg::VALUE_W-1:0] key_value_q;

	curq_pkg::curq_ctl_t          ctl;
	logic [PW-1:0]                wp_prev;
	logic [PW-1:0]                wp_next;
	logic [PW-1:0]                rp_next;
	logic                         full;
	logic [QUEUE_DEPTH-1:0]       hit_key;
	logic [QUEUE_DEPTH-1:0]       hit_val;

	logic [curq_pkg::MATCH_W-1:0] slot_match [QUEUE_DEPTH];
	logic [curq_pkg::INDEX_W-1:0] slot_index [QUEUE_DEPTH];
	logic [curq_pkg::VALUE_W-1:0] slot_value [QUEUE_DEPTH];
	logic [curq_pkg::MATCH_W-1:0] bus_match  [QUEUE_DEPTH];
	logic [curq_pkg::INDEX_W-1:0] bus_index  [QUEUE_DEPTH];
	logic [curq_pkg::VALUE_W-1:0] bus_value  [QUEUE_DEPTH];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] prev_ptr(input logic [PW-1:0] p);
		return (p == '0) ? LAST : p - 1'b1;
	endfunction

	assign wp_prev = prev_ptr(wp_q);
	assign wp_next = next_ptr(wp_q);
	assign rp_next = next_ptr(rp_q);
	// A full queue has the pointers equal while entries are pending.
	assign full    = !empty_q && (rp_q == wp_q);

	assign ctl.compare = (state_q == ST_CMP);
	assign ctl.shift   = (state_q == ST_SHIFT);
	assign ctl.append  = (state_q == ST_APPEND);

	// Row of slot cells. Each cell shifts from its upper neighbor on removal, and the
	// read chain runs from cell 0 upward: the cell at the read pointer injects its entry,
	// every other cell above cell 0 passes what its lower neighbor held, so the oldest entry moves up
	// the chain register by register until the top cell carries it.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam int NXT = (i + 1) % QUEUE_DEPTH;

		logic [curq_pkg::MATCH_W-1:0] chain_match;
		logic [curq_pkg::INDEX_W-1:0] chain_index;
		logic [curq_pkg::VALUE_W-1:0] chain_value;

		if (i == 0) begin : g_head
			assign chain_match = '0;
			assign chain_index = '0;
			assign chain_value = '0;
		end else begin : g_body
			assign chain_match = bus_match[i-1];
			assign chain_index = bus_index[i-1];
			assign chain_value = bus_value[i-1];
		end

		curq_cell #(
			.DEPTH (QUEUE_DEPTH),
			.INDEX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.rp           (rp_q),
			.wp           (wp_q),
			.scan_pos     (pos_q),
			.shift_end    (wp_prev),
			.key_match    (key_match_q),
			.key_index    (key_index_q),
			.key_value    (key_value_q),
			.nxt_match    (slot_match[NXT]),
			.nxt_index    (slot_index[NXT]),
			.nxt_value    (slot_value[NXT]),
			.bus_in_match (chain_match),
			.bus_in_index (chain_index),
			.bus_in_value (chain_value),
			.bus_match    (bus_match[i]),
			.bus_index    (bus_index[i]),
			.bus_value    (bus_value[i]),
			.slot_match   (slot_match[i]),
			.slot_index   (slot_index[i]),
			.slot_value   (slot_value[i]),
			.hit_key      (hit_key[i]),
			.hit_val      (hit_val[i])
		);
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_match_q <= match_id;
			key_index_q <= entry_index;
			key_value_q <= update_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			empty_q     <= 1'b1;
			pos_q       <= '0;
			pending_q   <= 1'b0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			notify_q    <= 1'b0;
			overwrote_q <= 1'b0;
			pop_valid_q <= 1'b0;
			out_match_q <= '0;
			out_index_q <= '0;
			out_value_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						unique case (command)
							curq_pkg::CMD_PUSH: begin
								state_q <= ST_CMP;
							end
							curq_pkg::CMD_POP: begin
								if (empty_q) begin
									// Nothing to return: an all-zero beat.
									done_q      <= 1'b1;
									notify_q    <= 1'b0;
									overwrote_q <= 1'b0;
									pop_valid_q <= 1'b0;
									out_match_q <= '0;
									out_index_q <= '0;
									out_value_q <= '0;
								end else begin
									state_q <= ST_POP;
								end
							end
							curq_pkg::CMD_CLEAR: begin
								rp_q        <= wp_q;
								empty_q     <= 1'b1;
								done_q      <= 1'b1;
								notify_q    <= 1'b0;
								overwrote_q <= 1'b0;
								pop_valid_q <= 1'b0;
								out_match_q <= '0;
								out_index_q <= '0;
								out_value_q <= '0;
							end
							default: begin
								// Unused command code: state untouched, all-zero beat.
								done_q      <= 1'b1;
								notify_q    <= 1'b0;
								overwrote_q <= 1'b0;
								pop_valid_q <= 1'b0;
								out_match_q <= '0;
								out_index_q <= '0;
								out_value_q <= '0;
							end
						endcase
					end
				end
				ST_CMP: begin
					// The cells register their hit flags at this edge; the scan then
					// starts at the newest entry and walks backward.
					pos_q     <= wp_prev;
					pending_q <= !empty_q;
					cnt_q     <= '0;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (hit_key[pos_q]) begin
						if (hit_val[pos_q]) begin
							// Same key, same value: the update is dropped silently.
							done_q      <= 1'b1;
							notify_q    <= 1'b0;
							overwrote_q <= 1'b0;
							pop_valid_q <= 1'b0;
							out_match_q <= '0;
							out_index_q <= '0;
							out_value_q <= '0;
							state_q     <= ST_IDLE;
						end else if (pending_q) begin
							state_q <= ST_SHIFT;
						end else begin
							state_q <= ST_APPEND;
						end
					end else begin
						// Once the scan passes the read pointer, older hits are already read.
						if (pos_q == rp_q) begin
							pending_q <= 1'b0;
						end
						pos_q <= prev_ptr(pos_q);
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LAST) begin
							state_q <= ST_APPEND;
						end
					end
				end
				ST_SHIFT: begin
					// The unread stale entry is squeezed out; the queue loses one entry
					// and may become empty, so the append that follows is never full.
					wp_q <= wp_prev;
					if (wp_prev == rp_q) begin
						empty_q <= 1'b1;
					end
					state_q <= ST_APPEND;
				end
				ST_APPEND: begin
					wp_q        <= wp_next;
					empty_q     <= 1'b0;
					done_q      <= 1'b1;
					notify_q    <= !full;
					overwrote_q <= full;
					pop_valid_q <= 1'b0;
					out_match_q <= '0;
					out_index_q <= '0;
					out_value_q <= '0;
					if (full) begin
						rp_q <= wp_next;
					end
					state_q <= ST_IDLE;
				end
				ST_POP: begin
					if (cnt_q == LAST) begin
						done_q      <= 1'b1;
						notify_q    <= 1'b0;
						overwrote_q <= 1'b0;
						pop_valid_q <= 1'b1;
						out_match_q <= bus_match[QUEUE_DEPTH-1];
						out_index_q <= bus_index[QUEUE_DEPTH-1];
						out_value_q <= bus_value[QUEUE_DEPTH-1];
						rp_q        <= rp_next;
						empty_q     <= (rp_next == wp_q);
						state_q     <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign notify    = notify_q;
	assign overwrote = overwrote_q;
	assign pop_valid = pop_valid_q;
	assign out_match = out_match_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;

endmodule

// ===== hdl/curq_checker.sv =====
// Port-level checker for the coalescing update ring queue, bound to the top level.
// Depends on coalescing_update_ring_queue_unit_macros.svh.
`include "coalescing_update_ring_queue_unit_macros.svh"

module curq_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic notify,
	input logic overwrote,
	input logic pop_valid
);

	// A push either wakes the reader or reports an overwrite, never both.
	`CURQ_ASSERT_NOW(a_notify_excl, done, !(notify && overwrote), "notify and overwrote together")

	// A popped entry carries no push status.
	`CURQ_ASSERT_NOW(a_pop_clean, done && pop_valid, !notify && !overwrote, "pop beat has push flags")

	// An accepted command either starts work or answers in the next cycle.
	`CURQ_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done, "accepted command lost")

	// No result beat appears without a command behind it.
	`CURQ_ASSERT_NEXT(a_no_phantom, !busy && !start, !done, "result beat without a command")

endmodule

bind coalescing_update_ring_queue_unit curq_checker u_curq_checker (.*);
